/* rtl/msd_pkg.sv */
// Package for the Morse stream decoder: payload structs, symbol and status codes,
// and the letter lookup for the dot/dash tree.
// No dependencies; used by morse_stream_decoder_unit.
`default_nettype none

package msd_pkg;

  localparam int unsigned MAX_MARKS = 4;
  localparam int unsigned TREE_SIZE = 29;
  localparam logic [5:0]  IDX_OUT   = 6'd63;

  localparam logic [15:0] CAP_RESET = 16'd256;

  localparam logic        KIND_CHAR = 1'b0;
  localparam logic        KIND_EOM  = 1'b1;

  localparam logic [7:0]  CH_DOT    = 8'h2E;
  localparam logic [7:0]  CH_DASH   = 8'h2D;
  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_NONE   = 8'h00;

  localparam logic [1:0]  ST_OK       = 2'd0;
  localparam logic [1:0]  ST_INVALID  = 2'd1;
  localparam logic [1:0]  ST_OVERFLOW = 2'd2;

  localparam logic        REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic       kind;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // Letter at a tree position; zero where the node carries no letter.
  function automatic logic [7:0] letter_lookup(input logic [5:0] idx);
    logic [7:0] ch;
    case (idx)
      6'd1:    ch = "e";
      6'd2:    ch = "t";
      6'd3:    ch = "i";
      6'd4:    ch = "a";
      6'd5:    ch = "n";
      6'd6:    ch = "m";
      6'd7:    ch = "s";
      6'd8:    ch = "u";
      6'd9:    ch = "r";
      6'd10:   ch = "w";
      6'd11:   ch = "d";
      6'd12:   ch = "k";
      6'd13:   ch = "g";
      6'd14:   ch = "o";
      6'd15:   ch = "h";
      6'd16:   ch = "v";
      6'd17:   ch = "f";
      6'd19:   ch = "l";
      6'd21:   ch = "p";
      6'd22:   ch = "j";
      6'd23:   ch = "b";
      6'd24:   ch = "x";
      6'd25:   ch = "c";
      6'd26:   ch = "y";
      6'd27:   ch = "z";
      6'd28:   ch = "q";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/morse_stream_decoder_unit.sv */
// Morse stream decoder top level: tree walk, letter emission, error handling
// and a two-entry result buffer. Depends on msd_pkg.
`default_nettype none

// A result is registered into the output register, or the skid register when
// the output stalls. Throughput: one item per cycle while in_ready is high;
// the decode state updates in a single pass through the letter lookup and the
// capacity compare. A two-entry result buffer (output plus skid register) lets
// input keep flowing while the output stalls; in_ready drops only when both hold data.
// Reset (rst_n low, synchronous) clears the decode state and the buffer and
// sets out_capacity to 256.
module morse_stream_decoder_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire msd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output msd_pkg::out_item_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [15:0] out_capacity_r;
  logic [5:0]  tree_index_r,    tree_index_nxt;
  logic [2:0]  mark_count_r,    mark_count_nxt;
  logic        after_letter_r,  after_letter_nxt;
  logic [15:0] chars_written_r, chars_written_nxt;
  logic        halted_r,        halted_nxt;

  msd_pkg::out_item_t out_item_r, skid_item_r, res_item;
  logic               out_valid_r, skid_valid_r;
  logic               res_valid;

  logic in_xfer, out_xfer, cfg_write;
  logic [7:0] cur_letter;
  logic [16:0] need;
  logic [6:0] next_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == msd_pkg::REG_CAPACITY) ? {16'd0, out_capacity_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_capacity_r <= msd_pkg::CAP_RESET;
    end else if (cfg_write && paddr[2] == msd_pkg::REG_CAPACITY) begin
      out_capacity_r <= pwdata[15:0];
    end
  end

  assign in_ready  = !skid_valid_r;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign out_xfer  = out_valid_r && out_ready;

  assign cur_letter = msd_pkg::letter_lookup(tree_index_r);
  assign need       = {1'b0, chars_written_r} + 17'd2;
  assign next_idx   = {tree_index_r, 1'b0} +
                      ((in_data.symbol == msd_pkg::CH_DOT) ? 7'd1 : 7'd2);

  always_comb begin
    tree_index_nxt    = tree_index_r;
    mark_count_nxt    = mark_count_r;
    after_letter_nxt  = after_letter_r;
    chars_written_nxt = chars_written_r;
    halted_nxt        = halted_r;
    res_valid         = 1'b0;
    res_item.out_char = msd_pkg::CH_NONE;
    res_item.status   = msd_pkg::ST_OK;
    res_item.last     = 1'b1;

    if (in_data.kind == msd_pkg::KIND_EOM) begin
      tree_index_nxt    = 6'd0;
      mark_count_nxt    = 3'd0;
      after_letter_nxt  = 1'b0;
      chars_written_nxt = 16'd0;
      halted_nxt        = 1'b0;
      if (!halted_r) begin
        res_valid = 1'b1;
        if (out_capacity_r == 16'd0) begin
          res_item.status = msd_pkg::ST_OVERFLOW;
        end else if (cur_letter == msd_pkg::CH_NONE) begin
          res_item.status = msd_pkg::ST_INVALID;
        end else begin
          res_item.out_char = cur_letter;
        end
      end
    end else if (!halted_r) begin
      if (need > {1'b0, out_capacity_r}) begin
        res_valid       = 1'b1;
        res_item.status = msd_pkg::ST_OVERFLOW;
        halted_nxt      = 1'b1;
      end else if (mark_count_r > 3'(msd_pkg::MAX_MARKS)) begin
        res_valid       = 1'b1;
        res_item.status = msd_pkg::ST_INVALID;
        halted_nxt      = 1'b1;
      end else if (after_letter_r && in_data.symbol == msd_pkg::CH_SPACE) begin
        // Second space right after a letter is a word gap.
        after_letter_nxt  = 1'b0;
        chars_written_nxt = chars_written_r + 16'd1;
        res_valid         = 1'b1;
        res_item.out_char = msd_pkg::CH_SPACE;
        res_item.last     = 1'b0;
      end else begin
        after_letter_nxt = 1'b0;
        if (in_data.symbol == msd_pkg::CH_SPACE) begin
          res_valid = 1'b1;
          if (cur_letter == msd_pkg::CH_NONE) begin
            res_item.status = msd_pkg::ST_INVALID;
            halted_nxt      = 1'b1;
          end else begin
            chars_written_nxt = chars_written_r + 16'd1;
            tree_index_nxt    = 6'd0;
            mark_count_nxt    = 3'd0;
            after_letter_nxt  = 1'b1;
            res_item.out_char = cur_letter;
            res_item.last     = 1'b0;
          end
        end else if (in_data.symbol != msd_pkg::CH_DOT &&
                     in_data.symbol != msd_pkg::CH_DASH) begin
          res_valid       = 1'b1;
          res_item.status = msd_pkg::ST_INVALID;
          halted_nxt      = 1'b1;
        end else begin
          // Positions past the tree collapse to one out-of-range marker.
          if (tree_index_r >= 6'(msd_pkg::TREE_SIZE) ||
              next_idx >= 7'(msd_pkg::TREE_SIZE)) begin
            tree_index_nxt = msd_pkg::IDX_OUT;
          end else begin
            tree_index_nxt = next_idx[5:0];
          end
          if (mark_count_r != 3'd7) begin
            mark_count_nxt = mark_count_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_index_r    <= 6'd0;
      mark_count_r    <= 3'd0;
      after_letter_r  <= 1'b0;
      chars_written_r <= 16'd0;
      halted_r        <= 1'b0;
    end else if (in_xfer) begin
      tree_index_r    <= tree_index_nxt;
      mark_count_r    <= mark_count_nxt;
      after_letter_r  <= after_letter_nxt;
      chars_written_r <= chars_written_nxt;
      halted_r        <= halted_nxt;
    end
  end

  // Result buffer: the skid register fills only while the output register
  // is stalled, and it drains into the output register first.
  logic push, out_free;
  assign push     = in_xfer && res_valid;
  assign out_free = !out_valid_r || out_xfer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_item_r <= skid_item_r;
        if (push) begin
          skid_item_r <= res_item;
        end
      end else if (push) begin
        out_item_r <= res_item;
      end
    end else if (push) begin
      skid_item_r <= res_item;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && res_valid && res_item.last && in_data.kind == msd_pkg::KIND_CHAR)
    |=> halted_r)
    else $error("error result did not halt the message");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (tree_index_r < 6'(msd_pkg::TREE_SIZE)) || (tree_index_r == msd_pkg::IDX_OUT))
    else $error("tree index left its legal range");

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && in_xfer && in_data.kind == msd_pkg::KIND_CHAR) |-> !res_valid)
    else $error("halted message produced a result");

endmodule

`default_nettype wire

/* test/morse_stream_decoder_unit_test.sv */
// Self-checking testbench for morse_stream_decoder_unit: directed and random Morse
// streams through valid/ready channels, capacity writes over the APB-style port.
// Depends on msd_pkg and the RTL top level only.
module morse_stream_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS  = 168;
  localparam logic [2:0]  CAPACITY_ADDR = 3'(4 * msd_pkg::REG_CAPACITY);

  // Letters along the dot/dash tree; zero marks a node with no letter.
  localparam logic [7:0] TREE_LETTERS [0:28] = '{
    8'h00, "e", "t", "i", "a", "n", "m", "s", "u", "r",
    "w", "d", "k", "g", "o", "h", "v", "f", 8'h00, "l",
    8'h00, "p", "j", "b", "x", "c", "y", "z", "q"};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  msd_pkg::in_item_t   in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  msd_pkg::out_item_t  out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  morse_stream_decoder_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Decoder state as predicted from the accepted transfers.
  logic [5:0]  dec_index;
  logic [2:0]  dec_marks;
  bit          dec_after_letter;
  int unsigned dec_written;
  bit          dec_halted;
  int unsigned dec_capacity;

  msd_pkg::in_item_t   symbol_queue[$];
  msd_pkg::out_item_t  predicted_chars[$];

  bit          idle_on = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned queued_count = 0;
  int unsigned items_sent = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned results_checked = 0;
  int unsigned overflow_seen = 0;
  int unsigned invalid_seen = 0;
  int unsigned capacity_writes = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  function automatic logic [7:0] tree_letter(input logic [5:0] idx);
    if (idx >= msd_pkg::TREE_SIZE) return msd_pkg::CH_NONE;
    return TREE_LETTERS[idx];
  endfunction

  task automatic clear_decoder_message();
    dec_index = '0;
    dec_marks = '0;
    dec_after_letter = 1'b0;
    dec_written = 0;
    dec_halted = 1'b0;
  endtask

  task automatic predict_decode(input msd_pkg::in_item_t item);
    msd_pkg::out_item_t res;
    bit          emit;
    bit          was_halted;
    logic [5:0]  idx;
    logic [7:0]  ch;
    int unsigned next;
    emit = 1'b0;
    res = '{out_char: msd_pkg::CH_NONE, status: msd_pkg::ST_OK, last: 1'b0};
    if (item.kind == msd_pkg::KIND_EOM) begin
      was_halted = dec_halted;
      idx = dec_index;
      clear_decoder_message();
      if (!was_halted) begin
        emit = 1'b1;
        res.last = 1'b1;
        ch = tree_letter(idx);
        if (dec_capacity == 0) res.status = msd_pkg::ST_OVERFLOW;
        else if (ch == msd_pkg::CH_NONE) res.status = msd_pkg::ST_INVALID;
        else res.out_char = ch;
      end
    end else if (!dec_halted) begin
      if (dec_written + 2 > dec_capacity) begin
        emit = 1'b1;
        res.status = msd_pkg::ST_OVERFLOW;
      end else if (dec_marks > msd_pkg::MAX_MARKS) begin
        emit = 1'b1;
        res.status = msd_pkg::ST_INVALID;
      end else if (dec_after_letter && item.symbol == msd_pkg::CH_SPACE) begin
        dec_after_letter = 1'b0;
        dec_written++;
        emit = 1'b1;
        res.out_char = msd_pkg::CH_SPACE;
      end else begin
        dec_after_letter = 1'b0;
        if (item.symbol == msd_pkg::CH_SPACE) begin
          ch = tree_letter(dec_index);
          emit = 1'b1;
          if (ch == msd_pkg::CH_NONE) begin
            res.status = msd_pkg::ST_INVALID;
          end else begin
            dec_written++;
            dec_index = '0;
            dec_marks = '0;
            dec_after_letter = 1'b1;
            res.out_char = ch;
          end
        end else if (item.symbol != msd_pkg::CH_DOT && item.symbol != msd_pkg::CH_DASH) begin
          emit = 1'b1;
          res.status = msd_pkg::ST_INVALID;
        end else begin
          if (dec_index >= msd_pkg::TREE_SIZE) begin
            dec_index = msd_pkg::IDX_OUT;
          end else begin
            next = 2 * dec_index + ((item.symbol == msd_pkg::CH_DOT) ? 1 : 2);
            dec_index = (next >= msd_pkg::TREE_SIZE) ? msd_pkg::IDX_OUT : 6'(next);
          end
          if (dec_marks < 3'd7) dec_marks++;
        end
      end
      // Every error result ends the message.
      if (emit && res.status != msd_pkg::ST_OK) begin
        dec_halted = 1'b1;
        res.last = 1'b1;
      end
    end
    if (emit) predicted_chars.push_back(res);
  endtask

  task automatic report_mismatch(input string why, input msd_pkg::out_item_t want,
                                 input msd_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"[%0t] result %0d %s: expected char %02h status %0d last %0b, ",
                "got char %02h status %0d last %0b"},
               $realtime, results_checked, why, want.out_char, want.status, want.last,
               got.out_char, got.status, got.last);
  endtask

  task automatic check_result(input msd_pkg::out_item_t got);
    msd_pkg::out_item_t want;
    results_checked++;
    if (got.status == msd_pkg::ST_OVERFLOW) overflow_seen++;
    if (got.status == msd_pkg::ST_INVALID) invalid_seen++;
    if (predicted_chars.size() == 0) begin
      report_mismatch("with nothing pending", '0, got);
    end else begin
      want = predicted_chars.pop_front();
      if (got.out_char !== want.out_char || got.status !== want.status || got.last !== want.last)
        report_mismatch("differs", want, got);
    end
  endtask

  // Sender: takes items from symbol_queue, with random idle bursts between transfers.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_decode(in_data);
        items_sent++;
      end else if (in_valid) begin
        input_stall_cycles++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (symbol_queue.size() > 0) begin
          in_data <= symbol_queue.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transfer, stalls in random bursts and on request for a long stretch.
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, predicted_chars.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_char(input logic [7:0] sym);
    symbol_queue.push_back('{kind: msd_pkg::KIND_CHAR, symbol: sym});
    queued_count++;
  endtask

  task automatic queue_end(input logic [7:0] sym);
    symbol_queue.push_back('{kind: msd_pkg::KIND_EOM, symbol: sym});
    queued_count++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  task automatic queue_marks(input int unsigned n);
    for (int i = 0; i < n; i++)
      queue_char($urandom_range(0, 1) ? msd_pkg::CH_DOT : msd_pkg::CH_DASH);
  endtask

  // Mostly well-formed letters and word spaces, with some overlong symbols,
  // stray bytes and extra spaces mixed in.
  task automatic queue_random_message();
    int unsigned letters;
    int unsigned roll;
    letters = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    for (int k = 0; k < letters; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        queue_marks($urandom_range(1, 4));
        queue_char(msd_pkg::CH_SPACE);
        if ($urandom_range(0, 3) == 0) queue_char(msd_pkg::CH_SPACE);
      end else if (roll < 78) begin
        queue_marks($urandom_range(5, 8));
        queue_char(msd_pkg::CH_SPACE);
      end else if (roll < 84) begin
        queue_char(($urandom_range(0, 7) == 0) ? msd_pkg::CH_NONE : 8'($urandom_range(0, 255)));
      end else if (roll < 90) begin
        queue_char(msd_pkg::CH_SPACE);
      end else begin
        queue_marks($urandom_range(1, 3));
      end
    end
    if ($urandom_range(0, 3) == 0) queue_marks($urandom_range(1, 5));
    else if ($urandom_range(0, 5) == 0) queue_char(msd_pkg::CH_SPACE);
    queue_end(8'($urandom_range(0, 255)));
  endtask

  task automatic write_capacity(input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dec_capacity = value;
    capacity_writes++;
  endtask

  // Holds off until every queued item has transferred and every result has come back.
  task automatic wait_quiet();
    while (symbol_queue.size() != 0 || in_valid || predicted_chars.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [15:0] cap;
    clear_decoder_message();
    dec_capacity = msd_pkg::CAP_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;

    // Letter, word space, then a third space.
    queue_text(".   ");
    queue_end(8'h00);
    // Leading space.
    queue_text(" ");
    queue_end(8'h00);
    // Node with no letter.
    queue_text("..-- ");
    queue_end(8'h00);
    // Five marks, then one more character.
    queue_text("-----.");
    queue_end(8'hFF);
    // Symbol that walks off the tree, pending at end of message.
    queue_text("----");
    queue_end(8'hFF);
    wait_quiet();

    write_capacity(16'd0);
    queue_text(".");
    queue_end(8'h00);
    queue_end(8'hFF);
    wait_quiet();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 5)
        0:       cap = 16'hFFFF;
        1:       cap = 16'($urandom_range(1, 3));
        2:       cap = 16'($urandom_range(4, 40));
        3:       cap = msd_pkg::CAP_RESET;
        default: cap = 16'($urandom_range(41, 200));
      endcase
      write_capacity(cap);
      if (phase == 3) hold_requests++;
      if (phase == RANDOM_PHASES - 1) idle_on = 1'b0;
      queued_count = 0;
      while (queued_count < PHASE_ITEMS) queue_random_message();
      wait_quiet();
    end

    mismatch_count += predicted_chars.size();
    $display("%0d items sent over %0d capacity settings; %0d results checked",
             items_sent, capacity_writes + 1, results_checked);
    $display("%0d overflow and %0d invalid-input endings; input held off for %0d cycles",
             overflow_seen, invalid_seen, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
